>>> rtl/lir_pkg.sv
// ---------------------------------------------------------------------------
// lir_pkg: shared types and constants of the linear interpolation resampler
// Field widths, register codes, reset values and the item and unit status
// structs used across the core and its serial arithmetic units.
// ---------------------------------------------------------------------------
package lir_pkg;

   localparam int RATE_W     = 18;
   localparam int SAMPLE_W   = 16;
   localparam int RESULT_CAP = 32;
   localparam int CSR_IDX_W  = 1;

   localparam int DEF_MAX_BURST   = 32;
   localparam int DEF_WEIGHT_BITS = 16;

   localparam logic [RATE_W-1:0] SOURCE_RATE_RESET = 18'd44100;
   localparam logic [RATE_W-1:0] TARGET_RATE_RESET = 18'd16000;

   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_RATE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_RATE = 1'd1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       stream_last;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] value;
      logic                       burst_end;
      logic                       stream_end;
      logic                       dropped;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic frac;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

>>> rtl/lir_div.sv
// ---------------------------------------------------------------------------
// lir_div: bit-serial restoring divider
// Produces one quotient bit per cycle. Integer mode divides an 18-bit value
// over 18 steps; fraction mode divides (numer << WEIGHT_BITS) by a larger
// divisor over WEIGHT_BITS steps, starting from numer as partial remainder.
// ---------------------------------------------------------------------------
module lir_div #(
   parameter int  WEIGHT_BITS = lir_pkg::DEF_WEIGHT_BITS,
   localparam int QW = (WEIGHT_BITS > lir_pkg::RATE_W) ? WEIGHT_BITS : lir_pkg::RATE_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lir_pkg::div_ctrl_type       ctrl,
   input  logic [lir_pkg::RATE_W-1:0]  numer,
   input  logic [lir_pkg::RATE_W-1:0]  divisor,
   output lir_pkg::unit_stat_type      stat,
   output logic [QW-1:0]               quotient,
   output logic [lir_pkg::RATE_W-1:0]  remainder
);
   import lir_pkg::*;

   localparam int CW = $clog2(QW + 1);

   logic [RATE_W-1:0] rem_ff, rem_in;
   logic [QW-1:0]     quo_ff, quo_in;
   logic [RATE_W-1:0] dvs_ff, dvs_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [RATE_W:0]   shifted;
   logic [RATE_W:0]   trial;
   logic              fits;

   assign shifted = {rem_ff, quo_ff[QW-1]};
   assign trial   = shifted - {1'b0, dvs_ff};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         dvs_in  = divisor;
         busy_in = 1'b1;
         if (ctrl.frac) begin
            rem_in = numer;
            quo_in = '0;
            cnt_in = CW'(WEIGHT_BITS);
         end else begin
            // align the dividend to the top so it shifts out msb first
            rem_in = '0;
            quo_in = QW'(numer) << (QW - RATE_W);
            cnt_in = CW'(RATE_W);
         end
      end else if (busy_ff) begin
         rem_in = fits ? trial[RATE_W-1:0] : shifted[RATE_W-1:0];
         quo_in = {quo_ff[QW-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

>>> rtl/lir_mul.sv
// ---------------------------------------------------------------------------
// lir_mul: bit-serial interpolation multiplier
// Multiplies (right - left) by an unsigned weight one weight bit per cycle
// with a shift-add accumulator, then rounds to nearest and adds left.
// ---------------------------------------------------------------------------
module lir_mul #(
   parameter int WEIGHT_BITS = lir_pkg::DEF_WEIGHT_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [lir_pkg::SAMPLE_W-1:0] left,
   input  logic signed [lir_pkg::SAMPLE_W-1:0] right,
   input  logic [WEIGHT_BITS-1:0]              weight,
   output lir_pkg::unit_stat_type              stat,
   output logic signed [lir_pkg::SAMPLE_W-1:0] value
);
   import lir_pkg::*;

   localparam int CW = $clog2(WEIGHT_BITS + 1);
   localparam int DW = SAMPLE_W + 1;
   localparam int HW = SAMPLE_W + 2;

   logic [SAMPLE_W-1:0]    left_ff, left_in;
   logic [DW-1:0]          diff_ff, diff_in;
   logic [HW-1:0]          hi_ff, hi_in;
   logic [WEIGHT_BITS-1:0] lo_ff, lo_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   logic [HW-1:0]          addend;
   logic [HW-1:0]          sum;
   logic [HW-1:0]          rounded;

   assign addend  = lo_ff[0] ? {diff_ff[DW-1], diff_ff} : '0;
   assign sum     = hi_ff + addend;
   // floor of the product plus the half bit gives round to nearest
   assign rounded = hi_ff + HW'(lo_ff[WEIGHT_BITS-1]);

   always_comb begin
      left_in = left_ff;
      diff_in = diff_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         left_in = left;
         diff_in = {right[SAMPLE_W-1], right} - {left[SAMPLE_W-1], left};
         hi_in   = '0;
         lo_in   = weight;
         cnt_in  = CW'(WEIGHT_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in  = {sum[HW-1], sum[HW-1:1]};
         lo_in  = {sum[0], lo_ff[WEIGHT_BITS-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff <= left_in;
      diff_ff <= diff_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign value     = left_ff + rounded[SAMPLE_W-1:0];

endmodule

>>> rtl/linear_interp_resampler_core.sv
// ---------------------------------------------------------------------------
// linear_interp_resampler_core: linear interpolation sample rate converter
// Converts a stream of signed 16-bit samples from source_rate to target_rate.
//
// Input items (sample, stream_last) enter on req_valid / req_stall; the core
// stalls while it works on one item. Each item yields zero to MAX_BURST
// results (capped at 32) on rsp_valid / rsp_stall, the last one flagged
// burst_end, and on a final item also stream_end. Outputs past the cap are
// dropped, flagged on every result of that item. Rates are written through
// csr_valid / csr_ready (always ready); the user must write them only while
// idle, which the core itself does not enforce. A rate of 0 acts as 1.
//
// The core has one shared bit-serial divider and one bit-serial multiplier.
// An item that crosses output positions runs two divisions, a final item
// with tail outputs one more, then each interpolated result a weight
// division and a multiply; a tail copy repeats the current sample.
// A result waits in the output register while the core takes the next item;
// a stalled receiver holds the core once a second result is ready.
// Reset restores the default rates and starts a fresh stream.
// ---------------------------------------------------------------------------
module linear_interp_resampler_core #(
   parameter int MAX_BURST   = lir_pkg::DEF_MAX_BURST,
   parameter int WEIGHT_BITS = lir_pkg::DEF_WEIGHT_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  lir_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output lir_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lir_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lir_pkg::RATE_W-1:0]     csr_wdata
);
   import lir_pkg::*;

   localparam int CAP   = (MAX_BURST < RESULT_CAP) ? MAX_BURST : RESULT_CAP;
   localparam int CNT_W = $clog2(CAP + 1);
   localparam int QW    = (WEIGHT_BITS > RATE_W) ? WEIGHT_BITS : RATE_W;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_K1       = 4'd1;
   localparam logic [3:0] ST_ADV      = 4'd2;
   localparam logic [3:0] ST_TAIL_CHK = 4'd3;
   localparam logic [3:0] ST_TAIL     = 4'd4;
   localparam logic [3:0] ST_EMIT     = 4'd5;
   localparam logic [3:0] ST_WDIV     = 4'd6;
   localparam logic [3:0] ST_MUL      = 4'd7;
   localparam logic [3:0] ST_OUT      = 4'd8;

   // control and stream state
   logic [3:0]          state_ff, state_in;
   logic [RATE_W-1:0]   src_ff, src_in;
   logic [RATE_W-1:0]   tgt_ff, tgt_in;
   logic [SAMPLE_W-1:0] prev_ff, prev_in;
   logic                have_ff, have_in;
   logic [RATE_W-1:0]   u_ff, u_in;
   logic [RATE_W-1:0]   r_ff, r_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // per-item working registers
   logic [SAMPLE_W-1:0] cur_ff, cur_in;
   logic                last_ff, last_in;
   logic [SAMPLE_W-1:0] left_ff, left_in;
   logic [RATE_W-1:0]   rm_ff, rm_in;
   logic [RATE_W-1:0]   unew_ff, unew_in;
   logic [RATE_W-1:0]   rnew_ff, rnew_in;
   logic [CNT_W-1:0]    n1_ff, n1_in;
   logic [CNT_W-1:0]    n2_ff, n2_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                drop_ff, drop_in;
   logic [SAMPLE_W-1:0] val_ff, val_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic [RATE_W-1:0]   s_eff;
   logic [RATE_W-1:0]   t_eff;
   logic [RATE_W-1:0]   r_clamp;
   logic [CNT_W-1:0]    total;
   logic [CNT_W-1:0]    idx_next;
   logic                out_free;
   logic                out_load;

   div_ctrl_type        div_ctrl;
   unit_stat_type       div_stat;
   logic [RATE_W-1:0]   div_numer;
   logic [RATE_W-1:0]   div_divisor;
   logic [QW-1:0]       div_quo;
   logic [RATE_W-1:0]   div_rem;

   logic                mul_start;
   unit_stat_type       mul_stat;
   logic [SAMPLE_W-1:0] mul_value;

   assign s_eff    = (src_ff == '0) ? RATE_W'(1) : src_ff;
   assign t_eff    = (tgt_ff == '0) ? RATE_W'(1) : tgt_ff;
   assign r_clamp  = (r_ff >= t_eff) ? t_eff - 1'b1 : r_ff;
   assign total    = n1_ff + n2_ff;
   assign idx_next = idx_ff + 1'b1;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_load = (state_ff == ST_OUT) && out_free;

   lir_div #(.WEIGHT_BITS(WEIGHT_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (div_ctrl),
      .numer     (div_numer),
      .divisor   (div_divisor),
      .stat      (div_stat),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   lir_mul #(.WEIGHT_BITS(WEIGHT_BITS)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .left   (left_ff),
      .right  (cur_ff),
      .weight (div_quo[WEIGHT_BITS-1:0]),
      .stat   (mul_stat),
      .value  (mul_value)
   );

   // rate registers
   always_comb begin
      src_in = src_ff;
      tgt_in = tgt_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_SOURCE_RATE: src_in = csr_wdata;
            REG_TARGET_RATE: tgt_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [RATE_W-1:0] k1;
      logic [RATE_W-1:0] k2;
      logic [RATE_W-1:0] excess;
      logic [CNT_W-1:0]  avail;

      k1     = div_quo[RATE_W-1:0] + RATE_W'(div_rem != '0);
      k2     = k1;
      excess = (div_rem == '0) ? '0 : s_eff - div_rem;
      avail  = CNT_W'(CAP) - n1_ff;

      state_in    = state_ff;
      prev_in     = prev_ff;
      have_in     = have_ff;
      u_in        = u_ff;
      r_in        = r_ff;
      cur_in      = cur_ff;
      last_in     = last_ff;
      left_in     = left_ff;
      rm_in       = rm_ff;
      unew_in     = unew_ff;
      rnew_in     = rnew_ff;
      n1_in       = n1_ff;
      n2_in       = n2_ff;
      idx_in      = idx_ff;
      drop_in     = drop_ff;
      val_in      = val_ff;
      div_ctrl    = '0;
      div_numer   = '0;
      div_divisor = t_eff;
      mul_start   = 1'b0;

      rsp_data_in            = rsp_data_ff;
      rsp_valid_in           = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur_in  = req_data.sample;
               last_in = req_data.stream_last;
               left_in = prev_ff;
               rm_in   = r_clamp;
               n1_in   = '0;
               n2_in   = '0;
               idx_in  = '0;
               drop_in = 1'b0;
               if (have_ff && u_ff == '0) begin
                  // outputs fall between the held sample and this one
                  div_ctrl.start = 1'b1;
                  div_numer      = t_eff - r_clamp;
                  div_divisor    = s_eff;
                  state_in       = ST_K1;
               end else begin
                  unew_in  = have_ff ? u_ff - 1'b1 : '0;
                  rnew_in  = r_clamp;
                  state_in = ST_TAIL_CHK;
               end
            end
         end
         ST_K1: begin
            if (div_stat.done) begin
               n1_in   = (k1 > RATE_W'(CAP)) ? CNT_W'(CAP) : k1[CNT_W-1:0];
               drop_in = k1 > RATE_W'(CAP);
               // overshoot past the next sample splits into whole samples and phase
               div_ctrl.start = 1'b1;
               div_numer      = excess;
               div_divisor    = t_eff;
               state_in       = ST_ADV;
            end
         end
         ST_ADV: begin
            if (div_stat.done) begin
               unew_in  = div_quo[RATE_W-1:0];
               rnew_in  = div_rem;
               state_in = ST_TAIL_CHK;
            end
         end
         ST_TAIL_CHK: begin
            if (last_ff && unew_ff == '0) begin
               div_ctrl.start = 1'b1;
               div_numer      = t_eff - rnew_ff;
               div_divisor    = s_eff;
               state_in       = ST_TAIL;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_TAIL: begin
            if (div_stat.done) begin
               n2_in    = (k2 > RATE_W'(avail)) ? avail : k2[CNT_W-1:0];
               drop_in  = drop_ff || (k2 > RATE_W'(avail));
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (idx_ff == total) begin
               // commit stream state, clear it after the final item
               if (last_ff) begin
                  prev_in = '0;
                  have_in = 1'b0;
                  u_in    = '0;
                  r_in    = '0;
               end else begin
                  prev_in = cur_ff;
                  have_in = 1'b1;
                  u_in    = unew_ff;
                  r_in    = rnew_ff;
               end
               state_in = ST_IDLE;
            end else if (idx_ff < n1_ff) begin
               div_ctrl.start = 1'b1;
               div_ctrl.frac  = 1'b1;
               div_numer      = rm_ff;
               div_divisor    = t_eff;
               state_in       = ST_WDIV;
            end else begin
               val_in   = cur_ff;
               state_in = ST_OUT;
            end
         end
         ST_WDIV: begin
            if (div_stat.done) begin
               mul_start = 1'b1;
               rm_in     = rm_ff + s_eff;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_stat.done) begin
               val_in   = mul_value;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.value      = val_ff;
               rsp_data_in.burst_end  = idx_next == total;
               rsp_data_in.stream_end = (idx_next == total) && last_ff;
               rsp_data_in.dropped    = drop_ff;
               idx_in                 = idx_next;
               state_in               = ST_EMIT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         src_ff       <= SOURCE_RATE_RESET;
         tgt_ff       <= TARGET_RATE_RESET;
         prev_ff      <= '0;
         have_ff      <= 1'b0;
         u_ff         <= '0;
         r_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         src_ff       <= src_in;
         tgt_ff       <= tgt_in;
         prev_ff      <= prev_in;
         have_ff      <= have_in;
         u_ff         <= u_in;
         r_ff         <= r_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      last_ff     <= last_in;
      left_ff     <= left_in;
      rm_ff       <= rm_in;
      unew_ff     <= unew_in;
      rnew_ff     <= rnew_in;
      n1_ff       <= n1_in;
      n2_ff       <= n2_in;
      idx_ff      <= idx_in;
      drop_ff     <= drop_in;
      val_ff      <= val_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

`ifndef ASSERT_OFF
   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_ctrl.start |-> !div_stat.busy)
      else $error("divider started while busy");

   a_out_in_range: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (idx_ff < total))
      else $error("result loaded beyond item count");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (({1'b0, n1_ff} + {1'b0, n2_ff}) <= (CNT_W + 1)'(CAP)))
      else $error("result count above burst cap");

   a_burst_end_idle: assert property (@(posedge clock) disable iff (reset)
      (out_load && rsp_data_in.burst_end) |=> (state_ff == ST_EMIT) ##1 (state_ff == ST_IDLE))
      else $error("item did not finish after its last result");
`endif

endmodule
